// File: src/timed_candidate_table_ranker_unit_defines.svh
// ----------------------------------------------------------------------------
// Timed candidate table ranker: assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TIMED_CANDIDATE_TABLE_RANKER_UNIT_DEFINES_SVH
`define TIMED_CANDIDATE_TABLE_RANKER_UNIT_DEFINES_SVH

`ifndef SYNTH
// checked property, disabled while in reset
`define TCR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked property, also during reset
`define TCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/tcr_pkg.sv
// ----------------------------------------------------------------------------
// Timed candidate table ranker: package
// Sizes, codes, word types and the source priority function.
// ----------------------------------------------------------------------------
package tcr_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int MAX_RETURN  = 64;
    localparam int CNT_W       = $clog2(MAX_RETURN + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 32;

    localparam logic [32:0] TTL_FLOOR = 33'd180000;
    localparam logic [32:0] TTL_EXTRA = 33'd120000;

    // request codes
    localparam logic REQ_OBSERVE  = 1'b0;
    localparam logic REQ_SNAPSHOT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 1'b1;

    // source kinds
    localparam logic [1:0] SRC_INIT   = 2'd0;
    localparam logic [1:0] SRC_SUBMIT = 2'd1;
    localparam logic [1:0] SRC_TAP    = 2'd2;
    localparam logic [1:0] SRC_OTHER  = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [63:0] instance_key;
        logic [63:0] voice_handle;
        logic [31:0] generation_tag;
        logic [63:0] time_us;
        logic [1:0]  source_kind;
        logic [15:0] confidence;
        logic [6:0]  max_count;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [63:0] out_key;
        logic [63:0] out_handle;
        logic [31:0] out_generation;
        logic [63:0] out_time_us;
        logic [1:0]  out_source;
        logic [15:0] out_confidence;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] handle;
        logic [31:0] generation;
        logic [63:0] tstamp;
        logic [1:0]  source;
        logic [15:0] conf;
    } entry_t;

    // submit ranks first, then init, tap, other
    function automatic logic [1:0] src_rank(input logic [1:0] src);
        logic [1:0] r;
        unique case (src)
            SRC_SUBMIT: r = 2'd0;
            SRC_INIT:   r = 2'd1;
            SRC_TAP:    r = 2'd2;
            default:    r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

// File: src/tcr_if.sv
// ----------------------------------------------------------------------------
// Timed candidate table ranker: channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface tcr_req_if
    import tcr_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcr_res_if
    import tcr_pkg::*;
();
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/timed_candidate_table_ranker_unit.sv
// Observe: one table scan from accept to ready again; an invalid observe is
//   dropped without a scan.
// Snapshot: one full scan of the 256-entry table per pick; unless the limit is
//   one, the first word waits for a second scan to learn whether it is the last
//   word; up to 64 scans per request, plus the output handshakes.
// Reset empties the table and restores both window registers.
// ----------------------------------------------------------------------------
// Timed candidate table ranker
// Keyed candidate table with expiry, refresh/insert and ranked snapshots.
// ----------------------------------------------------------------------------
`include "timed_candidate_table_ranker_unit_defines.svh"

module timed_candidate_table_ranker_unit
    import tcr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tcr_req_if.sink              req,
    tcr_res_if.source            res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [31:0] lookback_reg;
    logic [31:0] lookahead_reg;

    req_t        q_reg;
    logic [32:0] ttl_reg;
    logic [CNT_W-1:0] lim_reg;
    logic [CNT_W-1:0] cnt_reg;

    // entry memory and per-slot flags
    entry_t mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] taken_reg;

    // scan pipeline
    logic [IDX_W:0]   iss_reg;
    logic             p1_vld_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    entry_t           rd_reg;
    logic             p2_vld_reg;
    logic [IDX_W-1:0] p2_idx_reg;
    entry_t           p2_ent_reg;
    logic             p2_live_reg;
    logic             p2_cand_reg;
    logic [63:0]      p2_dist_reg;

    // snapshot selection
    logic             best_hit_reg;
    logic [IDX_W-1:0] best_idx_reg;
    entry_t           best_ent_reg;
    logic [63:0]      best_dist_reg;
    logic             pend_hit_reg;
    entry_t           pend_ent_reg;

    // observe search
    logic             match_hit_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [15:0]      match_conf_reg;
    logic             free_hit_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             old_hit_reg;
    logic [IDX_W-1:0] old_idx_reg;
    logic [63:0]      old_time_reg;

    res_t out_reg;
    logic out_vld_reg;

    // ------------------------------------------------------------------
    // Handshakes
    assign req.ready = (state_reg == ST_IDLE);
    assign res.valid = out_vld_reg;
    assign res.data  = out_reg;

    logic req_acc;
    logic res_acc;
    assign req_acc = req.valid && req.ready;
    assign res_acc = res.valid && res.ready;

    // ------------------------------------------------------------------
    // Stage 2 arithmetic: expiry, window and distance of one entry
    logic [63:0] age;
    logic        expired;
    logic [64:0] win_lo;
    logic [64:0] win_hi;
    logic        in_win;
    logic [63:0] tdist;
    logic [32:0] ttl_sum;

    assign age     = q_reg.time_us - rd_reg.tstamp;
    assign expired = (q_reg.time_us > rd_reg.tstamp) && (age > {31'd0, ttl_reg});
    assign win_lo  = {1'b0, rd_reg.tstamp} + {33'd0, lookback_reg};
    assign win_hi  = {1'b0, q_reg.time_us} + {33'd0, lookahead_reg};
    assign in_win  = (win_lo >= {1'b0, q_reg.time_us}) && (win_hi >= {1'b0, rd_reg.tstamp});
    assign tdist   = (rd_reg.tstamp > q_reg.time_us) ? rd_reg.tstamp - q_reg.time_us
                                                     : q_reg.time_us - rd_reg.tstamp;
    assign ttl_sum = {1'b0, lookahead_reg} + TTL_EXTRA;

    // ------------------------------------------------------------------
    // Stage 3 compare: does the stage-2 entry beat the current best
    logic [1:0] cur_pri;
    logic [1:0] best_pri;
    logic       better;

    assign cur_pri  = src_rank(p2_ent_reg.source);
    assign best_pri = src_rank(best_ent_reg.source);

    always_comb
    begin
        priority if (!best_hit_reg)
            better = 1'b1;
        else if (cur_pri != best_pri)
            better = cur_pri < best_pri;
        else if (p2_dist_reg != best_dist_reg)
            better = p2_dist_reg < best_dist_reg;
        else
            better = p2_ent_reg.conf > best_ent_reg.conf;
    end

    // ------------------------------------------------------------------
    // Observe write decision
    logic             obs_we;
    logic [IDX_W-1:0] obs_idx;
    entry_t           obs_ent;

    always_comb
    begin
        obs_ent.key        = q_reg.instance_key;
        obs_ent.handle     = q_reg.voice_handle;
        obs_ent.generation = q_reg.generation_tag;
        obs_ent.tstamp     = q_reg.time_us;
        obs_ent.source     = q_reg.source_kind;
        obs_ent.conf       = q_reg.confidence;
        obs_we  = 1'b0;
        obs_idx = free_idx_reg;
        priority if (match_hit_reg)
        begin
            obs_we  = 1'b1;
            obs_idx = match_idx_reg;
            if (match_conf_reg > q_reg.confidence)
                obs_ent.conf = match_conf_reg;
        end
        else if (free_hit_reg)
        begin
            obs_we = 1'b1;
        end
        else if (old_hit_reg && q_reg.time_us >= old_time_reg)
        begin
            obs_we  = 1'b1;
            obs_idx = old_idx_reg;
        end
        else
        begin
            obs_we = 1'b0;
        end
        obs_we = obs_we && (state_reg == ST_DECIDE) && (q_reg.req_type == REQ_OBSERVE);
    end

    // result words built from entries
    function automatic res_t mk_res(input entry_t e, input logic lst);
        res_t r;
        r.found          = 1'b1;
        r.out_key        = e.key;
        r.out_handle     = e.handle;
        r.out_generation = e.generation;
        r.out_time_us    = e.tstamp;
        r.out_source     = e.source;
        r.out_confidence = e.conf;
        r.last           = lst;
        return r;
    endfunction

    res_t empty_res;
    always_comb
    begin
        empty_res      = '0;
        empty_res.last = 1'b1;
    end

    logic [CNT_W-1:0] cnt_inc;
    assign cnt_inc = cnt_reg + 1'b1;

    logic scan_done;
    assign scan_done = iss_reg[IDX_W] && !p1_vld_reg && !p2_vld_reg;

    // ------------------------------------------------------------------
    // Entry memory: at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (obs_we)
            mem[obs_idx] <= obs_ent;
        rd_reg <= mem[iss_reg[IDX_W-1:0]];
    end

    // ------------------------------------------------------------------
    // Scan datapath registers
    always_ff @(posedge clk)
    begin
        p1_idx_reg  <= iss_reg[IDX_W-1:0];
        p2_idx_reg  <= p1_idx_reg;
        p2_ent_reg  <= rd_reg;
        p2_live_reg <= valid_reg[p1_idx_reg] && !expired;
        p2_cand_reg <= valid_reg[p1_idx_reg] && !expired && !taken_reg[p1_idx_reg] && in_win;
        p2_dist_reg <= tdist;
    end

    // ------------------------------------------------------------------
    // Sequencer, flags and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lookback_reg   <= 32'd150000;
            lookahead_reg  <= 32'd150000;
            valid_reg      <= '0;
            taken_reg      <= '0;
            iss_reg        <= '0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            best_hit_reg   <= 1'b0;
            best_idx_reg   <= '0;
            best_ent_reg   <= '0;
            best_dist_reg  <= '0;
            pend_hit_reg   <= 1'b0;
            pend_ent_reg   <= '0;
            match_hit_reg  <= 1'b0;
            match_idx_reg  <= '0;
            match_conf_reg <= '0;
            free_hit_reg   <= 1'b0;
            free_idx_reg   <= '0;
            old_hit_reg    <= 1'b0;
            old_idx_reg    <= '0;
            old_time_reg   <= '0;
            cnt_reg        <= '0;
            lim_reg        <= '0;
            ttl_reg        <= '0;
            q_reg          <= '0;
            out_reg        <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_LOOKBACK:  lookback_reg  <= cfg_wdata;
                    CFG_LOOKAHEAD: lookahead_reg <= cfg_wdata;
                    default:       ;
                endcase
            end

            // read issue and pipeline valids
            p1_vld_reg <= (state_reg == ST_SCAN) && !iss_reg[IDX_W];
            p2_vld_reg <= p1_vld_reg;
            if ((state_reg == ST_SCAN) && !iss_reg[IDX_W])
                iss_reg <= iss_reg + 1'b1;

            // expiry clears the slot as the scan passes it
            if (p1_vld_reg && expired)
                valid_reg[p1_idx_reg] <= 1'b0;

            // per-entry search
            if (p2_vld_reg)
            begin
                if (q_reg.req_type == REQ_SNAPSHOT)
                begin
                    if (p2_cand_reg && better)
                    begin
                        best_hit_reg  <= 1'b1;
                        best_idx_reg  <= p2_idx_reg;
                        best_ent_reg  <= p2_ent_reg;
                        best_dist_reg <= p2_dist_reg;
                    end
                end
                else
                begin
                    if (p2_live_reg && !match_hit_reg
                        && p2_ent_reg.key == q_reg.instance_key)
                    begin
                        match_hit_reg  <= 1'b1;
                        match_idx_reg  <= p2_idx_reg;
                        match_conf_reg <= p2_ent_reg.conf;
                    end
                    if (!p2_live_reg && !free_hit_reg)
                    begin
                        free_hit_reg <= 1'b1;
                        free_idx_reg <= p2_idx_reg;
                    end
                    if (p2_live_reg && (!old_hit_reg || p2_ent_reg.tstamp < old_time_reg))
                    begin
                        old_hit_reg  <= 1'b1;
                        old_idx_reg  <= p2_idx_reg;
                        old_time_reg <= p2_ent_reg.tstamp;
                    end
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_acc)
                    begin
                        q_reg         <= req.data;
                        ttl_reg       <= (ttl_sum < TTL_FLOOR) ? TTL_FLOOR : ttl_sum;
                        iss_reg       <= '0;
                        best_hit_reg  <= 1'b0;
                        match_hit_reg <= 1'b0;
                        free_hit_reg  <= 1'b0;
                        old_hit_reg   <= 1'b0;
                        pend_hit_reg  <= 1'b0;
                        cnt_reg       <= '0;
                        taken_reg     <= '0;
                        lim_reg       <= (req.data.max_count > 7'(MAX_RETURN))
                                         ? CNT_W'(MAX_RETURN) : CNT_W'(req.data.max_count);
                        if (req.data.req_type == REQ_OBSERVE)
                        begin
                            if (req.data.instance_key != '0 && req.data.voice_handle != '0
                                && req.data.time_us != '0)
                                state_reg <= ST_SCAN;
                        end
                        else if (req.data.time_us == '0 || req.data.max_count == '0)
                        begin
                            out_reg     <= empty_res;
                            out_vld_reg <= 1'b1;
                            state_reg   <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (scan_done)
                        state_reg <= ST_DECIDE;
                end

                ST_DECIDE:
                begin
                    if (q_reg.req_type == REQ_OBSERVE)
                    begin
                        if (obs_we)
                            valid_reg[obs_idx] <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else if (best_hit_reg)
                    begin
                        taken_reg[best_idx_reg] <= 1'b1;
                        cnt_reg      <= cnt_inc;
                        pend_ent_reg <= best_ent_reg;
                        if (pend_hit_reg)
                        begin
                            // the earlier pick is not the last one
                            out_reg     <= mk_res(pend_ent_reg, 1'b0);
                            out_vld_reg <= 1'b1;
                            state_reg   <= ST_OUT;
                        end
                        else if (cnt_inc == lim_reg)
                        begin
                            out_reg     <= mk_res(best_ent_reg, 1'b1);
                            out_vld_reg <= 1'b1;
                            state_reg   <= ST_OUT;
                        end
                        else
                        begin
                            pend_hit_reg <= 1'b1;
                            iss_reg      <= '0;
                            best_hit_reg <= 1'b0;
                            state_reg    <= ST_SCAN;
                        end
                    end
                    else
                    begin
                        // nothing more in window
                        out_reg      <= pend_hit_reg ? mk_res(pend_ent_reg, 1'b1) : empty_res;
                        out_vld_reg  <= 1'b1;
                        pend_hit_reg <= 1'b0;
                        state_reg    <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    if (res_acc)
                    begin
                        if (out_reg.last)
                        begin
                            out_vld_reg <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end
                        else if (cnt_reg == lim_reg)
                        begin
                            out_reg      <= mk_res(pend_ent_reg, 1'b1);
                            pend_hit_reg <= 1'b0;
                        end
                        else
                        begin
                            out_vld_reg  <= 1'b0;
                            iss_reg      <= '0;
                            best_hit_reg <= 1'b0;
                            state_reg    <= ST_SCAN;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    `TCR_ASSERT(a_empty_is_last, clk, rst_n,
        res.valid && !res.data.found |-> res.data.last, "empty word without last")
    `TCR_ASSERT(a_cnt_in_limit, clk, rst_n,
        cnt_reg <= lim_reg, "more picks than the limit")
    `TCR_ASSERT(a_last_ends, clk, rst_n,
        res_acc && res.data.last |=> !res.valid && req.ready, "words after last")
    `TCR_ASSERT_ALWAYS(a_no_overlap, clk,
        !(res.valid && req.ready), "request taken while a result is pending")

endmodule

// File: test/timed_candidate_table_ranker_unit_test.sv
// ----------------------------------------------------------------------------
// Timed candidate table ranker: regression bench
// Drives observe and snapshot words through the request channel and writes
// the window registers between phases. A table model in the bench predicts the
// result words, the typed-in empty answers apart, and each word is checked
// against it. The bench idles at random on both channels.
// ----------------------------------------------------------------------------
module timed_candidate_table_ranker_unit_test
    import tcr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 40000000;
    localparam int SETTLE      = 700;
    localparam int N_DIRECTED  = 18;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_wdata;

    tcr_req_if req ();
    tcr_res_if res ();

    timed_candidate_table_ranker_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .res       (res.source),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    // bench copy of the candidate table and window registers
    logic        cand_valid [TABLE_DEPTH];
    entry_t      cand       [TABLE_DEPTH];
    logic [31:0] win_back;
    logic [31:0] win_ahead;

    res_t pending_words[$];
    int   fail_count;
    int   cycles;
    bit   calm;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [1:0] prio(input logic [1:0] src);
        case (src)
            SRC_SUBMIT: return 2'd0;
            SRC_INIT:   return 2'd1;
            SRC_TAP:    return 2'd2;
            default:    return 2'd3;
        endcase
    endfunction

    function automatic logic [63:0] gap_to(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // drop entries older than the time-to-live
    function automatic void age_out(input logic [63:0] now);
        logic [32:0] ttl;
        ttl = {1'b0, win_ahead} + TTL_EXTRA;
        if (ttl < TTL_FLOOR)
            ttl = TTL_FLOOR;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (cand_valid[i] && now > cand[i].tstamp && now - cand[i].tstamp > {31'd0, ttl})
                cand_valid[i] = 1'b0;
    endfunction

    function automatic void store_observation(input req_t r);
        int free_slot;
        int oldest;
        entry_t e;
        free_slot = -1;
        oldest    = -1;
        if (r.instance_key == 0 || r.voice_handle == 0 || r.time_us == 0)
            return;
        age_out(r.time_us);
        e = '{r.instance_key, r.voice_handle, r.generation_tag, r.time_us,
              r.source_kind, r.confidence};
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (cand_valid[i] && cand[i].key == r.instance_key)
            begin
                if (cand[i].conf > e.conf)
                    e.conf = cand[i].conf;
                cand[i] = e;
                return;
            end
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (!cand_valid[i])
            begin
                if (free_slot < 0)
                    free_slot = i;
            end
            else if (oldest < 0 || cand[i].tstamp < cand[oldest].tstamp)
                oldest = i;
        if (free_slot >= 0)
        begin
            cand_valid[free_slot] = 1'b1;
            cand[free_slot] = e;
        end
        else if (oldest >= 0 && r.time_us >= cand[oldest].tstamp)
            cand[oldest] = e;
    endfunction

    function automatic bit in_window(input int i, input logic [63:0] q);
        logic [64:0] lo;
        logic [64:0] hi;
        lo = {1'b0, cand[i].tstamp} + {33'd0, win_back};
        hi = {1'b0, q} + {33'd0, win_ahead};
        return (lo >= {1'b0, q}) && ({1'b0, cand[i].tstamp} <= hi);
    endfunction

    function automatic bit ahead_of(input int a, input int b, input logic [63:0] q);
        if (prio(cand[a].source) != prio(cand[b].source))
            return prio(cand[a].source) < prio(cand[b].source);
        if (gap_to(cand[a].tstamp, q) != gap_to(cand[b].tstamp, q))
            return gap_to(cand[a].tstamp, q) < gap_to(cand[b].tstamp, q);
        if (cand[a].conf != cand[b].conf)
            return cand[a].conf > cand[b].conf;
        return a < b;
    endfunction

    // ranked snapshot: queue the expected words
    function automatic void rank_snapshot(input req_t r, input bit keep);
        bit   taken [TABLE_DEPTH];
        int   limit;
        int   best;
        int   n;
        res_t w;
        n = 0;
        limit = (r.max_count > MAX_RETURN) ? MAX_RETURN : int'(r.max_count);
        if (r.time_us != 0 && limit != 0)
        begin
            age_out(r.time_us);
            for (int i = 0; i < TABLE_DEPTH; i++)
                taken[i] = 1'b0;
            for (int k = 0; k < limit; k++)
            begin
                best = -1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (cand_valid[i] && !taken[i] && in_window(i, r.time_us))
                        if (best < 0 || ahead_of(i, best, r.time_us))
                            best = i;
                if (best < 0)
                    break;
                taken[best] = 1'b1;
                w = '{1'b1, cand[best].key, cand[best].handle, cand[best].generation,
                      cand[best].tstamp, cand[best].source, cand[best].conf, 1'b0};
                if (keep)
                    pending_words.insert(pending_words.size(), w);
                n++;
            end
        end
        if (!keep)
            return;
        if (n == 0)
        begin
            w = '0;
            w.last = 1'b1;
            pending_words.insert(pending_words.size(), w);
        end
        else
            pending_words[pending_words.size() - 1].last = 1'b1;
    endfunction

    // send one request word; the table model follows on acceptance
    task automatic send_word(input req_t r, input bit typed_empty);
        int gap;
        res_t w;
        gap = draw_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= r;
        do
            @(posedge clk);
        while (!req.ready);
        if (r.req_type == REQ_OBSERVE)
            store_observation(r);
        else
            rank_snapshot(r, !typed_empty);
        if (typed_empty)
        begin
            w = '0;
            w.last = 1'b1;
            pending_words.insert(pending_words.size(), w);
        end
    endtask

    // hold off until the block is idle
    task automatic drain();
        req.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_LOOKBACK)
            win_back = value;
        else
            win_ahead = value;
        @(posedge clk);
    endtask

    function automatic req_t mk(input logic t, input logic [63:0] key, input logic [63:0] h,
                                input logic [31:0] g, input logic [63:0] ts,
                                input logic [1:0] s, input logic [15:0] c,
                                input logic [6:0] m);
        return '{t, key, h, g, ts, s, c, m};
    endfunction

    // result sink with random stalls
    initial
    begin
        int stall;
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res.valid);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got = res.data;
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word: %p", got);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    fail_count++;
                end
                if (got.out_key !== want.out_key)
                begin
                    $error("out_key: expected %h, got %h", want.out_key, got.out_key);
                    fail_count++;
                end
                if (got.out_handle !== want.out_handle)
                begin
                    $error("out_handle: expected %h, got %h", want.out_handle, got.out_handle);
                    fail_count++;
                end
                if (got.out_generation !== want.out_generation)
                begin
                    $error("out_generation: expected %h, got %h",
                           want.out_generation, got.out_generation);
                    fail_count++;
                end
                if (got.out_time_us !== want.out_time_us)
                begin
                    $error("out_time_us: expected %0d, got %0d",
                           want.out_time_us, got.out_time_us);
                    fail_count++;
                end
                if (got.out_source !== want.out_source)
                begin
                    $error("out_source: expected %0d, got %0d", want.out_source, got.out_source);
                    fail_count++;
                end
                if (got.out_confidence !== want.out_confidence)
                begin
                    $error("out_confidence: expected %h, got %h",
                           want.out_confidence, got.out_confidence);
                    fail_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        req_t        plan [N_DIRECTED];
        bit          plan_empty [N_DIRECTED];
        logic [31:0] phase_back [5];
        logic [31:0] phase_ahead [5];
        logic [63:0] now;
        logic [63:0] key;
        logic [63:0] ts;
        logic [6:0]  cnt;
        req_t        r;
        int          sel;

        fail_count = 0;
        calm = 1'b0;
        rst_n     <= 1'b0;
        req.valid <= 1'b0;
        req.data  <= '0;
        cfg_we    <= 1'b0;
        cfg_idx   <= CFG_LOOKBACK;
        cfg_wdata <= '0;
        win_back  = 32'd150000;
        win_ahead = 32'd150000;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            cand_valid[i] = 1'b0;
            cand[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words; empty answers are typed in
        plan[0]  = mk(REQ_SNAPSHOT, 64'd5, 64'd5, 32'd0, 64'd1000, SRC_INIT, 16'd0, 7'd5);
        plan[1]  = mk(REQ_OBSERVE, 64'd0, 64'd7, 32'd1, 64'd500000, SRC_SUBMIT, 16'd9, 7'd0);
        plan[2]  = mk(REQ_OBSERVE, 64'd7, 64'd0, 32'd1, 64'd500000, SRC_SUBMIT, 16'd9, 7'd0);
        plan[3]  = mk(REQ_OBSERVE, 64'd7, 64'd7, 32'd1, 64'd0, SRC_SUBMIT, 16'd9, 7'd0);
        plan[4]  = mk(REQ_SNAPSHOT, 64'd0, 64'd0, 32'd0, 64'd500000, SRC_INIT, 16'd0, 7'd0);
        plan[5]  = mk(REQ_OBSERVE, '1, '1, '1, 64'd1000000, SRC_INIT, 16'hFFFF, 7'd0);
        plan[6]  = mk(REQ_OBSERVE, 64'd2, 64'd22, 32'd0, 64'd1000100, SRC_SUBMIT, 16'd0, 7'd0);
        plan[7]  = mk(REQ_OBSERVE, 64'd3, 64'd33, 32'd3, 64'd999900, SRC_TAP, 16'h8000, 7'd0);
        plan[8]  = mk(REQ_OBSERVE, 64'd4, 64'd44, 32'd4, 64'd1000100, SRC_OTHER, 16'h1234,
                      7'd0);
        plan[9]  = mk(REQ_OBSERVE, 64'd5, 64'd55, 32'd5, 64'd1000050, SRC_TAP, 16'h8000, 7'd0);
        plan[10] = mk(REQ_OBSERVE, 64'd2, 64'd23, 32'd6, 64'd1000200, SRC_SUBMIT, 16'd1, 7'd0);
        plan[11] = mk(REQ_SNAPSHOT, 64'd0, 64'd0, 32'd0, 64'd0, SRC_INIT, 16'd0, 7'd64);
        plan[12] = mk(REQ_SNAPSHOT, 64'd0, 64'd0, 32'd0, 64'd1000000, SRC_INIT, 16'd0, 7'd127);
        plan[13] = mk(REQ_SNAPSHOT, 64'd0, 64'd0, 32'd0, 64'd1000000, SRC_INIT, 16'd0, 7'd2);
        plan[14] = mk(REQ_SNAPSHOT, 64'd0, 64'd0, 32'd0, 64'd1200000, SRC_INIT, 16'd0, 7'd64);
        plan[15] = mk(REQ_OBSERVE, 64'd9, 64'd99, 32'd9, '1, SRC_TAP, 16'd7, 7'd0);
        plan[16] = mk(REQ_SNAPSHOT, 64'd0, 64'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFF0,
                      SRC_INIT, 16'd0, 7'd64);
        plan[17] = mk(REQ_SNAPSHOT, '1, '1, '1, 64'd1, SRC_OTHER, '1, 7'd1);
        plan_empty = '{1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0};
        for (int i = 0; i < N_DIRECTED; i++)
            send_word(plan[i], plan_empty[i]);

        // fill the table, then exercise eviction of the oldest entry
        drain();
        calm = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_word(mk(REQ_OBSERVE, 64'h1000 + i, 64'h5000 + i, i, 64'd2000000 + i * 10,
                         i[1:0], 16'(i * 97), 7'd0), 1'b0);
        send_word(mk(REQ_OBSERVE, 64'hAAAA, 64'h1, 32'd1, 64'd1999999, SRC_INIT, 16'd1, 7'd0),
                  1'b0);
        send_word(mk(REQ_OBSERVE, 64'hBBBB, 64'h2, 32'd2, 64'd2000000, SRC_SUBMIT, 16'd2, 7'd0),
                  1'b0);
        send_word(mk(REQ_OBSERVE, 64'hCCCC, 64'h3, 32'd3, 64'd2005000, SRC_TAP, 16'd3, 7'd0),
                  1'b0);
        send_word(mk(REQ_SNAPSHOT, 64'd0, 64'd0, 32'd0, 64'd2001000, SRC_INIT, 16'd0, 7'd64),
                  1'b0);
        calm = 1'b0;

        // random phases across window settings, extremes among them
        phase_back  = '{32'd150000, 32'd0, 32'hFFFF_FFFF, $urandom_range(0, 400000), $urandom()};
        phase_ahead = '{32'd150000, 32'd0, 32'hFFFF_FFFF, $urandom_range(0, 400000), $urandom()};
        now = 64'd3000000;
        for (int p = 0; p < 5; p++)
        begin
            drain();
            write_reg(CFG_LOOKBACK, phase_back[p]);
            write_reg(CFG_LOOKAHEAD, phase_ahead[p]);
            calm = (p == 3);
            for (int n = 0; n < 10; n++)
            begin
                sel = $urandom_range(0, 19);
                now = now + $urandom_range(0, 40000);
                ts  = now - $urandom_range(0, 200000);
                if (sel == 0)
                    ts = rand64();
                else if (sel == 1)
                    ts = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 300000);
                key = ($urandom_range(0, 9) == 0) ? rand64() : 64'd1 + $urandom_range(0, 40);
                cnt = 7'($urandom_range(1, 8));
                if (sel == 2)
                    cnt = 7'($urandom_range(0, 127));
                else if (sel == 3)
                    cnt = 7'd64;
                r = mk($urandom_range(0, 9) < 6 ? REQ_OBSERVE : REQ_SNAPSHOT, key, rand64(),
                       $urandom(), ts, 2'($urandom_range(0, 3)),
                       16'($urandom_range(0, 65535)), cnt);
                if ($urandom_range(0, 19) == 0)
                    r.instance_key = 0;
                if ($urandom_range(0, 19) == 0)
                    r.voice_handle = 0;
                if ($urandom_range(0, 29) == 0)
                    r.time_us = 0;
                send_word(r, 1'b0);
            end
        end

        drain();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
